// ===== src/ordered_list_insert_delete_macros.svh =====
// assertion helpers for the ordered list block
`ifndef ORDERED_LIST_INSERT_DELETE_MACROS_SVH
`define ORDERED_LIST_INSERT_DELETE_MACROS_SVH

// same-cycle implication, checked outside reset
`define OLID_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ordered list check failed");

// next-cycle implication, checked outside reset
`define OLID_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ordered list check failed");

`endif

// ===== src/olid_pkg.sv =====
package olid_pkg;

   // command codes
   typedef enum logic [1:0] {
      CMD_APPEND    = 2'd0,
      CMD_PUSH_HEAD = 2'd1,
      CMD_INSERT_AT = 2'd2,
      CMD_DELETE    = 2'd3
   } cmd_type;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_POS   = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   // control broadcast to every cell
   typedef struct packed {
      logic               ins;
      logic               del;
      logic signed [31:0] value;
   } cell_ctl_type;

endpackage

// ===== src/olid_cell.sv =====
module olid_cell #(
   parameter int CNT_W = 5,
   parameter int IDX   = 0
) (
   input  logic                  clock,
   input  olid_pkg::cell_ctl_type ctl,
   input  logic [CNT_W-1:0]      ins_pos,
   input  logic [CNT_W-1:0]      count,
   input  logic signed [31:0]    left_data,
   input  logic signed [31:0]    right_data,
   input  logic                  hit_in,
   output logic signed [31:0]    data,
   output logic                  hit_out
);
   import olid_pkg::*;

   localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

   logic signed [31:0] data_ff;
   logic signed [31:0] data_in;
   logic               occupied;
   logic               match;

   // local compare, first-hit chain passes to the right
   assign occupied = MyIdx < count;
   assign match    = occupied && (data_ff == ctl.value);
   assign hit_out  = hit_in | match;
   assign data     = data_ff;

   // shift right on insert, shift left from the hit on delete
   always_comb begin
      data_in = data_ff;
      if (ctl.ins) begin
         if (MyIdx > ins_pos) begin
            data_in = left_data;
         end else if (MyIdx == ins_pos) begin
            data_in = ctl.value;
         end
      end else if (ctl.del && hit_out) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// ===== src/ordered_list_insert_delete.sv =====
// an accepted beat is held in the execute stage, then its result in the response register
// throughput: one command per cycle while the response side takes beats
// the command executes across the row of cells, the first match for a delete
// ripples through the cells' hit chain
// reset (synchronous, active high) empties the list and drops pending beats
module ordered_list_insert_delete #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic signed [31:0] req_value,
   input  logic [4:0]         req_position,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [4:0]         rsp_count
);
   import olid_pkg::*;

`include "ordered_list_insert_delete_macros.svh"

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CW    = ((CNT_W > 5) ? CNT_W : 5) + 1;
   localparam logic [CNT_W-1:0] Full = CNT_W'(DEPTH);

   // execute stage
   logic               ex_valid_ff, ex_valid_in;
   cmd_type            ex_cmd_ff;
   logic signed [31:0] ex_value_ff;
   logic [4:0]         ex_pos_ff;

   // list count
   logic [CNT_W-1:0]   count_ff, count_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic [4:0]         rsp_count_ff, rsp_count_in;

   logic               out_free, fire, accept;
   logic               found, is_full, is_empty, bad_pos;
   logic [CW-1:0]      pos_ext, cnt_ext, new_cnt_ext;
   logic [CNT_W-1:0]   ins_pos;
   logic [2:0]         status;
   logic               do_ins, do_del;
   cell_ctl_type       ctl;

   logic signed [31:0] cell_data [DEPTH];
   logic               hit [DEPTH+1];

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = ex_valid_ff && out_free;
   assign req_stall = ex_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign ex_valid_in = accept || (ex_valid_ff && !fire);

   // command decode and status
   assign is_full  = count_ff == Full;
   assign is_empty = count_ff == '0;
   assign pos_ext  = CW'(ex_pos_ff);
   assign cnt_ext  = CW'(count_ff);
   assign bad_pos  = (ex_pos_ff == 5'd0) || (pos_ext > cnt_ext + CW'(1));
   assign found    = hit[DEPTH];

   always_comb begin
      status  = ST_OK;
      do_ins  = 1'b0;
      do_del  = 1'b0;
      ins_pos = '0;
      case (ex_cmd_ff)
         CMD_APPEND: begin
            ins_pos = count_ff;
            if (is_full) status = ST_FULL;
            else do_ins = 1'b1;
         end
         CMD_PUSH_HEAD: begin
            ins_pos = '0;
            if (is_full) status = ST_FULL;
            else do_ins = 1'b1;
         end
         CMD_INSERT_AT: begin
            ins_pos = CNT_W'(pos_ext - CW'(1));
            if (bad_pos) status = ST_BAD_POS;
            else if (is_full) status = ST_FULL;
            else do_ins = 1'b1;
         end
         CMD_DELETE: begin
            if (is_empty) status = ST_EMPTY;
            else if (!found) status = ST_NOT_FOUND;
            else do_del = 1'b1;
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   // broadcast to the cells, gated by the execute handshake
   assign ctl.ins   = fire && do_ins;
   assign ctl.del   = fire && do_del;
   assign ctl.value = ex_value_ff;

   // count and response
   always_comb begin
      count_in = count_ff;
      if (ctl.ins) count_in = count_ff + CNT_W'(1);
      else if (ctl.del) count_in = count_ff - CNT_W'(1);
      new_cnt_ext   = CW'(count_in);
      rsp_valid_in  = fire || (rsp_valid_ff && rsp_stall);
      rsp_status_in = fire ? status : rsp_status_ff;
      rsp_count_in  = fire ? new_cnt_ext[4:0] : rsp_count_ff;
   end

   // row of cells
   assign hit[0] = 1'b0;
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [31:0] left_d, right_d;
      if (g == 0) begin : g_head
         assign left_d = ex_value_ff;
      end else begin : g_mid
         assign left_d = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
         assign right_d = cell_data[g];
      end else begin : g_body
         assign right_d = cell_data[g+1];
      end
      olid_cell #(
         .CNT_W (CNT_W),
         .IDX   (g)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .ins_pos    (ins_pos),
         .count      (count_ff),
         .left_data  (left_d),
         .right_data (right_d),
         .hit_in     (hit[g]),
         .data       (cell_data[g]),
         .hit_out    (hit[g+1])
      );
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         ex_valid_ff  <= ex_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         ex_cmd_ff   <= cmd_type'(req_cmd);
         ex_value_ff <= req_value;
         ex_pos_ff   <= req_position;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

   // checks
   `OLID_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= Full)
   `OLID_ASSERT_NEXT(a_fire_gives_rsp, clock, reset, fire, rsp_valid_ff)
   `OLID_ASSERT_NEXT(a_ins_grows, clock, reset, ctl.ins, count_ff == $past(count_ff) + CNT_W'(1))
   `OLID_ASSERT_NOW(a_del_has_hit, clock, reset, ctl.del, found && !is_empty)

endmodule
